// File: rtl/rational_arith_unit_core_defines.svh
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("rau assertion");
`define RAU_ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("rau assertion");
`else
`define RAU_ASSERT(label, clk, rst_n, prop)
`define RAU_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: rtl/rau_pkg.sv
// Package: types, constants and helpers of the rational arithmetic unit.
`default_nettype none
package rau_pkg;
	localparam int unsigned WIDTH_DEF = 32;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned EXP_W = 6;
	localparam int unsigned FIELD_W = 32;

	typedef enum logic [2:0] {
		KIND_ADD = 3'd0,
		KIND_SUB = 3'd1,
		KIND_MUL = 3'd2,
		KIND_DIV = 3'd3,
		KIND_POW = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_POW,
		ST_GCD_CHK,
		ST_GCD_DIV,
		ST_RED_N,
		ST_RED_NW,
		ST_RED_D,
		ST_RED_DW,
		ST_SIGN,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic quot;
	} div_ctl_t;
endpackage
`default_nettype wire

// File: rtl/rau_divider.sv
// Shared signed truncating divider, one quotient bit per cycle.
`default_nettype none
module rau_divider #(
	parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire rau_pkg::div_ctl_t ctl,
	input  wire logic [WIDTH-1:0] dividend,
	input  wire logic [WIDTH-1:0] divisor,
	output logic                  busy,
	output logic [WIDTH-1:0]      result
);
	import rau_pkg::*;
	localparam int unsigned CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q, quo_q, dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             nq_q, nr_q, quot_q;
	logic [WIDTH:0]   trial;
	logic [WIDTH-1:0] ma, mb;

	assign ma = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign mb = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
	assign trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, dsr_q};
	assign busy = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= CW'(WIDTH);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= '0;
			quo_q  <= ma;
			dsr_q  <= mb;
			nq_q   <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
			nr_q   <= dividend[WIDTH-1];
			quot_q <= ctl.quot;
		end else if (busy) begin
			if (!trial[WIDTH]) begin
				rem_q <= trial[WIDTH-1:0];
				quo_q <= {quo_q[WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
				quo_q <= {quo_q[WIDTH-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (quot_q) begin
			result = nq_q ? (~quo_q + 1'b1) : quo_q;
		end else begin
			result = nr_q ? (~rem_q + 1'b1) : rem_q;
		end
	end
endmodule
`default_nettype wire

// File: rtl/rational_arith_unit_core.sv
// Top level of the rational arithmetic unit: sequencer, multiplier and divider.
// One transfer in, one transfer out. An item first forms the raw fraction (for power,
// per exponent bit: multiply in the base where the bit is set, then square the base),
// then runs Euclid's gcd with one divide per step on the shared bit-serial divider, two
// more divides to reduce, and a sign fix. No new item is taken until the result
// has been transferred out.
`default_nettype none
`include "rational_arith_unit_core_defines.svh"
module rational_arith_unit_core #(
	parameter int unsigned WIDTH = rau_pkg::WIDTH_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// a_num[31:0], a_den[63:32], b_num[95:64], b_den[127:96], exponent[133:128], zeros
	input  wire logic [135:0] s_tdata,
	// kind[2:0]
	input  wire logic [2:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// result_num[31:0], result_den[63:32]
	output logic [63:0]       m_tdata,
	// error[0]
	output logic              m_tuser
);
	import rau_pkg::*;

	state_t            st_q, st_d;
	logic [KIND_W-1:0] kind_q;
	logic [WIDTH-1:0]  an_q, ad_q, bn_q, bd_q, num_q, den_q, t_q, ga_q, gb_q;
	logic [EXP_W-1:0]  e_q;
	logic              err_q;
	logic [1:0]        pstep_q;
	logic [WIDTH-1:0]  mx, my, prod;
	div_ctl_t          dctl;
	logic [WIDTH-1:0]  dvd, dvs, dres;
	logic              dbusy;

	function automatic logic [WIDTH-1:0] fld(input logic [31:0] v);
		logic [63:0] s;
		s = {{32{v[31]}}, v};
		return s[WIDTH-1:0];
	endfunction

	function automatic logic [31:0] tof(input logic [WIDTH-1:0] v);
		logic [63:0] s;
		s = 64'(signed'(v));
		return s[31:0];
	endfunction

	assign prod = WIDTH'(mx * my);

	rau_divider #(.WIDTH(WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(dctl), .dividend(dvd), .divisor(dvs),
		.busy(dbusy), .result(dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		mx = an_q;
		my = bd_q;
		dctl = '0;
		dvd = ga_q;
		dvs = gb_q;
		case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == KIND_POW) begin
						st_d = ST_POW;
					end else if (s_tuser > KIND_POW) begin
						st_d = ST_GCD_CHK;
					end else begin
						st_d = ST_M1;
					end
				end
			end
			ST_M1: begin
				mx = an_q;
				my = (kind_q == KIND_MUL) ? bn_q : bd_q;
				st_d = ST_M2;
			end
			ST_M2: begin
				mx = (kind_q == KIND_MUL || kind_q == KIND_DIV) ? ad_q : bn_q;
				my = (kind_q == KIND_DIV) ? bn_q : ((kind_q == KIND_MUL) ? bd_q : ad_q);
				st_d = (kind_q == KIND_MUL || kind_q == KIND_DIV) ? ST_GCD_CHK : ST_M3;
			end
			ST_M3: begin
				mx = ad_q;
				my = bd_q;
				st_d = ST_GCD_CHK;
			end
			ST_POW: begin
				case (pstep_q)
					2'd0: begin
						mx = num_q;
						my = an_q;
					end
					2'd1: begin
						mx = den_q;
						my = ad_q;
					end
					2'd2: begin
						mx = an_q;
						my = an_q;
					end
					default: begin
						mx = ad_q;
						my = ad_q;
					end
				endcase
				if (e_q == '0) begin
					st_d = ST_GCD_CHK;
				end
			end
			ST_GCD_CHK: begin
				if (gb_q == '0) begin
					st_d = (ga_q == '0) ? ST_SIGN : ST_RED_N;
				end else begin
					dctl.start = 1'b1;
					st_d = ST_GCD_DIV;
				end
			end
			ST_GCD_DIV: begin
				if (!dbusy) begin
					st_d = ST_GCD_CHK;
				end
			end
			ST_RED_N: begin
				dvd = num_q;
				dvs = ga_q;
				dctl.start = 1'b1;
				dctl.quot = 1'b1;
				st_d = ST_RED_NW;
			end
			ST_RED_NW: begin
				if (!dbusy) begin
					st_d = ST_RED_D;
				end
			end
			ST_RED_D: begin
				dvd = den_q;
				dvs = ga_q;
				dctl.start = 1'b1;
				dctl.quot = 1'b1;
				st_d = ST_RED_DW;
			end
			ST_RED_DW: begin
				if (!dbusy) begin
					st_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				st_d = ST_OUT;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				kind_q  <= s_tuser;
				an_q    <= fld(s_tdata[31:0]);
				ad_q    <= fld(s_tdata[63:32]);
				bn_q    <= fld(s_tdata[95:64]);
				bd_q    <= fld(s_tdata[127:96]);
				e_q     <= s_tdata[133:128];
				pstep_q <= '0;
				err_q   <= 1'b0;
				ga_q    <= '0;
				gb_q    <= '0;
				if (s_tuser > KIND_POW) begin
					num_q <= '0;
					den_q <= '0;
				end else begin
					num_q <= WIDTH'(1);
					den_q <= WIDTH'(1);
				end
			end
			ST_M1: begin
				t_q <= prod;
				if (kind_q == KIND_MUL || kind_q == KIND_DIV) begin
					num_q <= prod;
				end
			end
			ST_M2: begin
				if (kind_q == KIND_MUL || kind_q == KIND_DIV) begin
					den_q <= prod;
					ga_q  <= num_q;
					gb_q  <= prod;
				end else begin
					num_q <= (kind_q == KIND_SUB) ? (t_q - prod) : (t_q + prod);
				end
			end
			ST_M3: begin
				den_q <= prod;
				ga_q  <= num_q;
				gb_q  <= prod;
			end
			ST_POW: begin
				if (e_q == '0) begin
					ga_q <= num_q;
					gb_q <= den_q;
				end else begin
					pstep_q <= pstep_q + 2'd1;
					case (pstep_q)
						2'd0: begin
							if (e_q[0]) begin
								num_q <= prod;
							end
						end
						2'd1: begin
							if (e_q[0]) begin
								den_q <= prod;
							end
						end
						2'd2: begin
							an_q <= prod;
						end
						default: begin
							ad_q <= prod;
							e_q  <= e_q >> 1;
						end
					endcase
				end
			end
			ST_GCD_CHK: begin
				if (gb_q == '0) begin
					if (ga_q == '0) begin
						err_q <= 1'b1;
					end else if (ga_q[WIDTH-1]) begin
						ga_q <= ~ga_q + 1'b1;
					end
				end else begin
					ga_q <= gb_q;
				end
			end
			ST_GCD_DIV: begin
				if (!dbusy) begin
					gb_q <= dres;
				end
			end
			ST_RED_D: begin
				num_q <= dres;
			end
			ST_RED_DW: begin
				if (!dbusy) begin
					den_q <= dres;
				end
			end
			ST_SIGN: begin
				if (den_q[WIDTH-1]) begin
					num_q <= ~num_q + 1'b1;
					den_q <= ~den_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = {tof(den_q), tof(num_q)};
	assign m_tuser = err_q;

	`RAU_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid)
	`RAU_ASSERT(a_excl, clk, arst_n, !(s_tready && m_tvalid))
	`RAU_ASSERT(a_div_idle, clk, arst_n, dctl.start |-> !dbusy)
endmodule
`default_nettype wire
